### src/itsm_pkg.sv
// ----------------------------------------------------------------------------
// itsm_pkg: shared types and constants for the integer ternary search
// Coordinate and coefficient widths, register indexes, reciprocal constant
// for the divide by three, and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package itsm_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int SCAN_MARGIN     = 5;
  localparam int COEF_WIDTH      = 16;
  localparam int FVAL_WIDTH      = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = COEF_WIDTH;

  // register indexes on the config port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_SQUARE = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_LINEAR = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_CONST  = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIND_MAX    = CFG_INDEX_WIDTH'(3);

  // span of the working interval, one bit wider than a coordinate
  localparam int SPAN_WIDTH  = COORD_WIDTH + 1;
  // span/3 for a span below 2^COORD_WIDTH
  localparam int THIRD_WIDTH = COORD_WIDTH - 1;
  // floor(n/3) = (n * ceil(2^(W+2)/3)) >> (W+2) for n < 2^W
  localparam int DIV3_SHIFT  = COORD_WIDTH + 2;
  localparam logic [COORD_WIDTH:0] DIV3_MUL =
    (COORD_WIDTH + 1)'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

  // pipeline depth of the quadratic evaluator
  localparam int EVAL_LATENCY = 3;
  localparam int WAIT_WIDTH   = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [FVAL_WIDTH-1:0]  fval_t;

  typedef struct packed {
    logic load_in;     // take a new interval
    logic mid_en;      // capture the third points
    logic upd_narrow;  // narrow the interval from the two values
    logic scan_sel;    // evaluators look at low/high instead of third points
    logic scan_cmp;    // compare a scanned point against the candidate
    logic scan_first;  // first compare: candidate is high itself
    logic load_out;    // move the candidate into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic span_gt_margin;
    logic low_lt_high;
  } dp_status_t;

endpackage

### src/itsm_if.sv
// ----------------------------------------------------------------------------
// itsm_if: valid/ready channels of the integer ternary search
// Query channel carries the interval, result channel carries the point found.
// ----------------------------------------------------------------------------
interface itsm_query_if import itsm_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t low_bound;
  coord_t high_bound;

  modport source (output valid, low_bound, high_bound, input ready);
  modport sink (input valid, low_bound, high_bound, output ready);
endinterface

interface itsm_result_if import itsm_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t best_x;

  modport source (output valid, best_x, input ready);
  modport sink (input valid, best_x, output ready);
endinterface

### src/itsm_eval.sv
// ----------------------------------------------------------------------------
// itsm_eval: three-stage evaluator of a*x*x + b*x + c
// Horner form, second product split in two halves, result modulo 2^64.
// ----------------------------------------------------------------------------
module itsm_eval import itsm_pkg::*; (
  input  logic   clk,
  input  coord_t x,
  input  coef_t  coef_square,
  input  coef_t  coef_linear,
  input  coef_t  coef_const,
  output fval_t  fx
);

  localparam int AX_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int T_WIDTH   = AX_WIDTH + 1;
  localparam int TH_WIDTH  = T_WIDTH - COEF_WIDTH;
  localparam int PH_WIDTH  = TH_WIDTH + COORD_WIDTH;
  localparam int PL_WIDTH  = COEF_WIDTH + 1 + COORD_WIDTH;
  localparam int SUM_WIDTH = (PH_WIDTH + COEF_WIDTH + 1 > FVAL_WIDTH) ?
                             PH_WIDTH + COEF_WIDTH + 1 : FVAL_WIDTH;

  logic signed [AX_WIDTH-1:0]   ax;
  logic signed [T_WIDTH-1:0]    t;
  coord_t                       x1;
  logic signed [TH_WIDTH-1:0]   t_hi;
  logic signed [COEF_WIDTH:0]   t_lo;
  logic signed [PH_WIDTH-1:0]   ph_next;
  logic signed [PL_WIDTH-1:0]   pl_next;
  logic signed [PH_WIDTH-1:0]   ph;
  logic signed [PL_WIDTH-1:0]   pl;
  logic signed [SUM_WIDTH-1:0]  sum;

  // stage 1: t = a*x + b
  assign ax = coef_square * x;

  always_ff @(posedge clk) begin
    t  <= T_WIDTH'(ax) + T_WIDTH'(coef_linear);
    x1 <= x;
  end

  // stage 2: t*x as high and low partial products
  assign t_hi    = $signed(t[T_WIDTH-1:COEF_WIDTH]);
  assign t_lo    = $signed({1'b0, t[COEF_WIDTH-1:0]});
  assign ph_next = t_hi * x1;
  assign pl_next = t_lo * x1;

  always_ff @(posedge clk) begin
    ph <= ph_next;
    pl <= pl_next;
  end

  // stage 3: recombine and add c
  assign sum = (SUM_WIDTH'(ph) <<< COEF_WIDTH) + SUM_WIDTH'(pl) + SUM_WIDTH'(coef_const);

  always_ff @(posedge clk) begin
    fx <= sum[FVAL_WIDTH-1:0];
  end

endmodule

### src/itsm_dp.sv
// ----------------------------------------------------------------------------
// itsm_dp: datapath of the integer ternary search
// Config registers, working interval, divide by three, two evaluators,
// candidate registers and the output register.
// ----------------------------------------------------------------------------
module itsm_dp import itsm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  coord_t                     low_bound,
  input  coord_t                     high_bound,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  output coord_t                     best_x
);

  coef_t  coef_square;
  coef_t  coef_linear;
  coef_t  coef_const;
  logic   find_max;

  coord_t cur_low;
  coord_t cur_high;
  coord_t m1;
  coord_t m2;
  coord_t best_pos;
  fval_t  best_val;

  logic signed [SPAN_WIDTH-1:0] span;
  logic [2*COORD_WIDTH:0]       div_prod;
  logic [THIRD_WIDTH-1:0]       third;
  coord_t                       third_c;

  coord_t x_a;
  coord_t x_b;
  fval_t  f_a;
  fval_t  f_b;

  fval_t  ref_val;
  coord_t ref_pos;
  logic   take_a;

  function automatic logic better(input fval_t p, input fval_t q, input logic maxm);
    return maxm ? (p > q) : (p < q);
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_square <= COEF_WIDTH'(2);
      coef_linear <= -COEF_WIDTH'(4);
      coef_const  <= COEF_WIDTH'(2);
      find_max    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_SQUARE: coef_square <= cfg_data;
        REG_COEF_LINEAR: coef_linear <= cfg_data;
        REG_COEF_CONST:  coef_const  <= cfg_data;
        REG_FIND_MAX:    find_max    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // span and loop status
  assign span = SPAN_WIDTH'(cur_high) - SPAN_WIDTH'(cur_low);
  assign status.span_gt_margin = span > SPAN_WIDTH'(SCAN_MARGIN);
  assign status.low_lt_high    = cur_low < cur_high;

  // span/3 by reciprocal; span is below 2^COORD_WIDTH whenever it is used
  always_ff @(posedge clk) begin
    div_prod <= span[COORD_WIDTH-1:0] * DIV3_MUL;
  end

  assign third   = div_prod[2*COORD_WIDTH:DIV3_SHIFT];
  assign third_c = coord_t'({1'b0, third});

  always_ff @(posedge clk) begin
    if (cmd.mid_en) begin
      m1 <= cur_low + third_c;
      m2 <= cur_high - third_c;
    end
  end

  // evaluators
  assign x_a = cmd.scan_sel ? cur_low  : m1;
  assign x_b = cmd.scan_sel ? cur_high : m2;

  itsm_eval u_eval_a (
    .clk         (clk),
    .x           (x_a),
    .coef_square (coef_square),
    .coef_linear (coef_linear),
    .coef_const  (coef_const),
    .fx          (f_a)
  );

  itsm_eval u_eval_b (
    .clk         (clk),
    .x           (x_b),
    .coef_square (coef_square),
    .coef_linear (coef_linear),
    .coef_const  (coef_const),
    .fx          (f_b)
  );

  // scan candidate: on the first compare it is high with f(high)
  assign ref_val = cmd.scan_first ? f_b      : best_val;
  assign ref_pos = cmd.scan_first ? cur_high : best_pos;
  assign take_a  = status.low_lt_high && better(f_a, ref_val, find_max);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_low  <= low_bound;
      cur_high <= high_bound;
    end else if (cmd.upd_narrow) begin
      if (better(f_a, f_b, find_max)) begin
        cur_high <= m2;
      end else begin
        cur_low <= m1;
      end
    end else if (cmd.scan_cmp && status.low_lt_high) begin
      cur_low <= cur_low + coord_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_cmp) begin
      best_pos <= take_a ? cur_low : ref_pos;
      best_val <= take_a ? f_a     : ref_val;
    end
    if (cmd.load_out) begin
      best_x <= best_pos;
    end
  end

  // each narrowing round shrinks the interval
  a_narrow_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_narrow |=> span < $past(span))
    else $error("narrowing round did not shrink the interval");

  // third points stay ordered inside the interval
  a_third_order: assert property (@(posedge clk) disable iff (rst)
    cmd.mid_en |=> (m1 <= m2) && (m1 > cur_low) && (m2 < cur_high))
    else $error("third points out of order");

endmodule

### src/itsm_ctrl.sv
// ----------------------------------------------------------------------------
// itsm_ctrl: sequencer of the integer ternary search
// Runs narrowing rounds, then the linear scan, and owns the channel flags.
// ----------------------------------------------------------------------------
module itsm_ctrl import itsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int STATE_WIDTH = 4;
  localparam logic [STATE_WIDTH-1:0] ST_IDLE  = 4'd0;
  localparam logic [STATE_WIDTH-1:0] ST_DIV   = 4'd1;
  localparam logic [STATE_WIDTH-1:0] ST_MID   = 4'd2;
  localparam logic [STATE_WIDTH-1:0] ST_NWAIT = 4'd3;
  localparam logic [STATE_WIDTH-1:0] ST_NUPD  = 4'd4;
  localparam logic [STATE_WIDTH-1:0] ST_SWAIT = 4'd5;
  localparam logic [STATE_WIDTH-1:0] ST_SCMP  = 4'd6;
  localparam logic [STATE_WIDTH-1:0] ST_STEST = 4'd7;
  localparam logic [STATE_WIDTH-1:0] ST_DONE  = 4'd8;

  localparam logic [WAIT_WIDTH-1:0] WAIT_LOAD = WAIT_WIDTH'(EVAL_LATENCY - 1);

  logic [STATE_WIDTH-1:0] state;
  logic [STATE_WIDTH-1:0] state_next;
  logic [WAIT_WIDTH-1:0]  wait_cnt;
  logic [WAIT_WIDTH-1:0]  wait_cnt_next;
  logic                   first;
  logic                   first_next;
  logic                   out_valid_next;

  always_comb begin
    state_next    = state;
    wait_cnt_next = wait_cnt;
    first_next    = first;
    cmd           = '0;
    in_ready      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        wait_cnt_next = WAIT_LOAD;
        if (status.span_gt_margin) begin
          state_next = ST_MID;
        end else begin
          first_next = 1'b1;
          state_next = ST_SWAIT;
        end
      end
      ST_MID: begin
        cmd.mid_en    = 1'b1;
        wait_cnt_next = WAIT_LOAD;
        state_next    = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (wait_cnt == '0) begin
          state_next = ST_NUPD;
        end else begin
          wait_cnt_next = wait_cnt - WAIT_WIDTH'(1);
        end
      end
      ST_NUPD: begin
        cmd.upd_narrow = 1'b1;
        state_next     = ST_DIV;
      end
      ST_SWAIT: begin
        cmd.scan_sel = 1'b1;
        if (wait_cnt == '0) begin
          state_next = ST_SCMP;
        end else begin
          wait_cnt_next = wait_cnt - WAIT_WIDTH'(1);
        end
      end
      ST_SCMP: begin
        cmd.scan_cmp   = 1'b1;
        cmd.scan_first = first;
        first_next     = 1'b0;
        state_next     = ST_STEST;
      end
      ST_STEST: begin
        wait_cnt_next = WAIT_LOAD;
        state_next    = status.low_lt_high ? ST_SWAIT : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wait_cnt  <= '0;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wait_cnt  <= wait_cnt_next;
      first     <= first_next;
      out_valid <= out_valid_next;
    end
  end

  // a result only shows up after a finished search
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done state");

  // scan compare waits out the full evaluator latency
  a_scan_latency: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCMP |-> $past(state) == ST_SWAIT && $past(wait_cnt) == '0)
    else $error("scan compare before evaluator output is ready");

endmodule

### src/integer_ternary_search_min.sv
// ----------------------------------------------------------------------------
// integer_ternary_search_min: integer ternary search on a quadratic
// Finds the point of [low_bound, high_bound] where a*x*x + b*x + c is
// smallest (or largest, with find_max set); narrowing rounds, then a scan.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents             | handshake
//  ---------+-----+---------------------------+-------------------------------
//  query    | in  | low_bound, high_bound     | valid/ready
//  result   | out | best_x                    | valid/ready
//  cfg      | in  | cfg_index, cfg_data       | cfg_write, no back-pressure
//
//  Sequence: take a query beat, run narrowing rounds until a span test ends
//  the narrowing, then scan each remaining point (the first compare also loads
//  high as the candidate, and an empty scan still makes one pass), then hand
//  off the result from the done state back to idle, with about 37 rounds for a
//  full 24-bit span and at most SCAN_MARGIN scanned points.
//  A round consists of the reciprocal divide by three, the third-point add, the
//  three-stage evaluator pipeline and the compare that narrows the interval.
//  Reset (rst, synchronous) clears the sequencer and loads 2x^2 - 4x + 2.
//  Stalls: a query beat is taken whenever the sequencer is idle, even while
//  the previous result waits; a search that finishes with the output still
//  full holds until result.ready frees it.
//
module integer_ternary_search_min import itsm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  itsm_query_if.sink                 query,
  itsm_result_if.source              result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: state machine and channel flags
  itsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config registers, interval, evaluators, candidate, output reg
  itsm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .low_bound  (query.low_bound),
    .high_bound (query.high_bound),
    .cmd        (cmd),
    .status     (status),
    .best_x     (result.best_x)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for integer_ternary_search_min
// Drives intervals on the query channel and checks every best_x beat against
// a software ternary search of the same quadratic. Both channels idle at
// random, the result side holds off once for a long stretch, and the
// coefficients and search mode change between phases.
// ----------------------------------------------------------------------------
module tb_top import itsm_pkg::*;;

  localparam int CLK_HIGH       = 4;
  localparam int CLK_LOW        = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int SEARCH_CYCLES  = 400;
  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int LONG_HOLD      = 3000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_QUERIES  = 105;

  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_WIDTH - 1));
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;

  logic clk = 1'b0;
  logic rst;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  itsm_query_if  query_ch ();
  itsm_result_if result_ch ();

  integer_ternary_search_min u_top (
    .clk       (clk),
    .rst       (rst),
    .query     (query_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Expected best points, one per accepted interval, oldest first.
  // --------------------------------------------------------------------------
  typedef struct {
    coord_t lo;
    coord_t hi;
    coord_t best;
  } search_expect_t;

  class best_point_board;
    coef_t          sq;
    coef_t          lin;
    coef_t          cst;
    bit             want_max;
    search_expect_t pending_best[$];
    int             errors;

    function new();
      sq       = coef_t'(2);
      lin      = coef_t'(-4);
      cst      = coef_t'(2);
      want_max = 1'b0;
      errors   = 0;
    endfunction

    function void set_coefs(coef_t a, coef_t b, coef_t c, bit mx);
      sq       = a;
      lin      = b;
      cst      = c;
      want_max = mx;
    endfunction

    // quadratic at 64 bits, wrapping like the hardware
    function longint fval(longint x);
      return longint'(sq) * x * x + longint'(lin) * x + longint'(cst);
    endfunction

    function bit improves(longint p, longint q);
      return want_max ? (p > q) : (p < q);
    endfunction

    function coord_t locate_best(coord_t lo_in, coord_t hi_in);
      longint lo, hi, third, m1, m2, pos, val, v;
      lo = lo_in;
      hi = hi_in;
      while (hi - lo > SCAN_MARGIN) begin
        third = (hi - lo) / 3;
        m1 = lo + third;
        m2 = hi - third;
        // a tie moves low up
        if (improves(fval(m1), fval(m2))) hi = m2;
        else lo = m1;
      end
      // high is the first candidate, lower points must be strictly better
      pos = hi;
      val = fval(hi);
      while (lo < hi) begin
        v = fval(lo);
        if (improves(v, val)) begin
          pos = lo;
          val = v;
        end
        lo++;
      end
      return coord_t'(pos);
    endfunction

    function void note_query(coord_t lo, coord_t hi);
      search_expect_t e;
      e.lo   = lo;
      e.hi   = hi;
      e.best = locate_best(lo, hi);
      pending_best.push_back(e);
    endfunction

    function void check_result(coord_t got);
      search_expect_t e;
      if (pending_best.size() == 0) begin
        errors++;
        $display("%0t: best_x %0d arrived with no query outstanding", $time, got);
        return;
      end
      e = pending_best.pop_front();
      if (got !== e.best) begin
        errors++;
        $display("%0t: best_x for [%0d, %0d]: expected %0d, actual %0d",
                 $time, e.lo, e.hi, e.best, got);
      end
    endfunction

    function int pending();
      return pending_best.size();
    endfunction
  endclass

  best_point_board board = new();

  bit tx_burst  = 1'b0;
  bit rx_burst  = 1'b0;
  int long_hold = 0;

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Query side. valid stays high from one beat to the next when no gap is
  // drawn, so it never gets two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_query(coord_t lo, coord_t hi);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      query_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_ch.valid      <= 1'b1;
    query_ch.low_bound  <= lo;
    query_ch.high_bound <= hi;
    do @(posedge clk); while (query_ch.ready !== 1'b1);
    board.note_query(lo, hi);
  endtask

  // wait for every outstanding beat before touching the registers
  task automatic drain();
    query_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // all four registers on consecutive edges; write enable drops once at the end
  task automatic load_config(coef_t a, coef_t b, coef_t c, bit mx);
    cfg_write <= 1'b1;
    cfg_index <= REG_COEF_SQUARE;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_COEF_LINEAR;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= REG_COEF_CONST;
    cfg_data  <= c;
    @(posedge clk);
    // upper data bits are don't-care for the mode bit
    cfg_index <= REG_FIND_MAX;
    cfg_data  <= (CFG_DATA_WIDTH'($urandom) & ~CFG_DATA_WIDTH'(1)) | CFG_DATA_WIDTH'(mx);
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_coefs(a, b, c, mx);
  endtask

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Intervals mostly sit around the vertex so the narrowing has a real
  // extremum to chase; the rest are tight spans, full-range ordered pairs and
  // unordered pairs that are often reversed.
  task automatic send_random();
    longint center, lo, hi, half, t;
    int     kind;
    kind = $urandom_range(0, 99);
    if (board.sq == 0) center = longint'($urandom_range(0, 2000)) - 1000;
    else center = -longint'(board.lin) / (2 * longint'(board.sq));
    if (kind < 10) begin
      lo = longint'(coord_t'($urandom));
      hi = longint'(coord_t'($urandom));
    end else if (kind < 35) begin
      lo = center + longint'($urandom_range(0, 128)) - 64;
      hi = lo + longint'($urandom_range(0, 12));
    end else if (kind < 75) begin
      half = longint'($urandom_range(0, 1 << $urandom_range(2, 22)));
      lo = center - longint'($urandom_range(0, int'(half)));
      hi = center + longint'($urandom_range(0, int'(half)));
    end else begin
      lo = longint'(coord_t'($urandom));
      hi = longint'(coord_t'($urandom));
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end
    send_query(coord_t'(clamp_coord(lo)), coord_t'(clamp_coord(hi)));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall before each beat, occasional stretches with no
  // stall, and one long hold-off that fills the block and stalls the query.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        stall     = long_hold;
        long_hold = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 10);
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      board.check_result(result_ch.best_x);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    coord_t cmin, cmax;
    cmin = coord_t'(COORD_MIN);
    cmax = coord_t'(COORD_MAX);

    query_ch.valid      <= 1'b0;
    query_ch.low_bound  <= '0;
    query_ch.high_bound <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_COEF_SQUARE;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients 2x^2 - 4x + 2, minimum at x = 1
    send_query(cmin, cmax);               // widest span
    send_query(cmin, cmin);
    send_query(cmax, cmax);
    send_query(coord_t'(0), coord_t'(0));
    send_query(coord_t'(1), coord_t'(1));
    send_query(coord_t'(-5), coord_t'(0));  // span at the margin: scan only
    send_query(coord_t'(-6), coord_t'(0));  // one past the margin
    send_query(cmax, cmin);               // reversed: answer is high
    send_query(coord_t'(5), coord_t'(-5));
    send_query(coord_t'(-100), coord_t'(100));
    send_query(cmin, coord_t'(0));
    send_query(coord_t'(0), cmax);
    send_query(cmax - coord_t'(5), cmax);
    send_query(cmin, cmin + coord_t'(6));
    drain();

    // x^2: symmetric intervals give equal values at the third points
    load_config(coef_t'(1), coef_t'(0), coef_t'(0), 1'b0);
    send_query(coord_t'(-6), coord_t'(6));
    send_query(coord_t'(-9), coord_t'(9));
    send_query(coord_t'(-7), coord_t'(7));
    send_query(coord_t'(-300), coord_t'(300));
    send_query(cmin + coord_t'(1), cmax);
    drain();

    // flat function in max mode: every compare ties, high must win
    load_config(coef_t'(0), coef_t'(0), coef_t'(-32768), 1'b1);
    send_query(coord_t'(-2), coord_t'(2));
    send_query(coord_t'(-100), coord_t'(100));
    send_query(coord_t'(3), coord_t'(3));
    send_query(coord_t'(10), coord_t'(-10));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_config(coef_t'(32767), coef_t'(-32768), coef_t'(32767), 1'b0);
        1: load_config(coef_t'(-32768), coef_t'(32767), coef_t'(-32768), 1'b1);
        2: load_config(coef_t'(-32768), coef_t'(-32768), coef_t'(-32768), 1'b0);
        3: load_config(coef_t'(32767), coef_t'(32767), coef_t'(32767), 1'b1);
        4: load_config(coef_t'(2), coef_t'(-4), coef_t'(2), 1'b0);
        default: begin
          load_config(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                      1'($urandom));
        end
      endcase
      // result side stops for a while; queries keep coming until it stalls
      if (phase == 1) long_hold = LONG_HOLD;
      repeat (PHASE_QUERIES) send_random();
      drain();
    end

    repeat (SEARCH_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
